>>> src/assert_macros.svh
// assertion helpers for the point list table
// compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)

`define ASSERT_NEVER(label, clk, rst, expr, msg)

`endif

`endif

>>> src/plt_pkg.sv
package plt_pkg;

   // default list depth
   localparam int DEPTH_DEF = 32;

   // operation codes
   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_POP    = 3'd1;
   localparam logic [2:0] OP_DELETE = 3'd2;
   localparam logic [2:0] OP_RADIUS = 3'd3;
   localparam logic [2:0] OP_MEMBER = 3'd4;
   localparam logic [2:0] OP_COUNT  = 3'd5;

   // status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_EMPTY     = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND = 2'd2;
   localparam logic [1:0] ST_FULL      = 2'd3;

   // cell commands
   localparam logic [2:0] CELL_HOLD = 3'd0;
   localparam logic [2:0] CELL_PUSH = 3'd1;
   localparam logic [2:0] CELL_POP  = 3'd2;
   localparam logic [2:0] CELL_DEL  = 3'd3;
   localparam logic [2:0] CELL_ROT  = 3'd4;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
   } point_type;

   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] coord_x;
      logic signed [31:0] coord_y;
      logic [63:0]        radius_sq;
   } req_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic               point_valid;
      logic               found;
      logic [5:0]         entry_count;
      logic [1:0]         status;
      logic               last;
   } rsp_type;

   // command broadcast to every cell
   typedef struct packed {
      logic [2:0] op;
      point_type  key;
   } cell_ctrl_type;

   // result of the norm unit
   typedef struct packed {
      logic      valid;
      logic      match;
      point_type pt;
   } norm_out_type;

endpackage

>>> src/point_list_table_top.sv
// Point list table: up to DEPTH signed 2-D points kept newest first in a chain
// of cells, one point per cell. Push, pop, delete of the newest exact match,
// membership test and count act on the whole chain at once: every cell compares
// its point with the key and shifts toward or away from the head in the same
// edge. A radius query rotates the list through the head cell into one shared
// norm unit (squares, then sum and compare, two register stages); it holds the
// block until its final result is loaded, longer while the result side stalls, and
// gives one result per matching point, newest first, the final one marked
// last, or a single empty result. A new item is taken only while no query is
// running and the result register is free or being drained.
`include "assert_macros.svh"

module point_list_table_top import plt_pkg::*; #(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(DEPTH + 1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_SCAN = 1'b1;

   logic          state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] rot_ff, rot_in;
   logic [63:0]   rsq_ff, rsq_in;
   point_type     pend_ff, pend_in;
   logic          pend_v_ff, pend_v_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   cell_ctrl_type ctrl;
   point_type     pts [DEPTH];
   logic [DEPTH-1:0] occ_vec;
   logic [DEPTH:0]   seen;
   point_type     key;

   norm_out_type  nout;
   logic          busy;
   logic          out_free, accept, advance, issue, scan_done;
   logic          full, empty, found;
   rsp_type       resp;
   logic          load;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == S_IDLE) && out_free);
   assign accept    = req_valid && !req_stall;

   assign key.x = req_data.coord_x;
   assign key.y = req_data.coord_y;
   assign full  = (cnt_ff == CW'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign found = seen[DEPTH];

   // query scan control
   assign advance   = (state_ff == S_SCAN) && out_free;
   assign issue     = advance && (rot_ff != cnt_ff);
   assign scan_done = advance && (rot_ff == cnt_ff) && !busy;

   // chain of cells, cell 0 holds the newest point
   assign seen[0] = 1'b0;
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      point_type lpt, rpt;
      logic      locc, rocc;
      if (i == 0) begin : g_head
         assign lpt  = key;
         assign locc = 1'b1;
      end else begin : g_mid
         assign lpt  = pts[i-1];
         assign locc = occ_vec[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
         assign rpt  = '0;
         assign rocc = 1'b0;
      end else begin : g_inner
         assign rpt  = pts[i+1];
         assign rocc = occ_vec[i+1];
      end
      plt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl),
         .left_pt  (lpt),
         .left_occ (locc),
         .right_pt (rpt),
         .right_occ(rocc),
         .head_pt  (pts[0]),
         .seen_in  (seen[i]),
         .pt       (pts[i]),
         .occ      (occ_vec[i]),
         .seen_out (seen[i+1])
      );
   end

   // shared norm unit fed from the head cell
   plt_norm u_norm (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_valid(issue),
      .in_pt   (pts[0]),
      .rsq     (rsq_ff),
      .nout    (nout),
      .busy    (busy)
   );

   // operation decode and result build
   always_comb begin
      ctrl.op   = CELL_HOLD;
      ctrl.key  = key;
      cnt_in    = cnt_ff;
      state_in  = state_ff;
      rot_in    = rot_ff;
      rsq_in    = rsq_ff;
      pend_in   = pend_ff;
      pend_v_in = pend_v_ff;
      resp      = '0;
      resp.last = 1'b1;
      load      = 1'b0;
      if (accept) begin
         load = 1'b1;
         case (req_data.opcode)
            OP_PUSH: begin
               if (full) begin
                  resp.status = ST_FULL;
               end else begin
                  ctrl.op = CELL_PUSH;
                  cnt_in  = CW'(cnt_ff + 1'b1);
               end
            end
            OP_POP: begin
               if (empty) begin
                  resp.status = ST_EMPTY;
               end else begin
                  ctrl.op = CELL_POP;
                  cnt_in  = CW'(cnt_ff - 1'b1);
               end
            end
            OP_DELETE: begin
               if (empty) begin
                  resp.status = ST_EMPTY;
               end else if (!found) begin
                  resp.status = ST_NOT_FOUND;
               end else begin
                  ctrl.op = CELL_DEL;
                  cnt_in  = CW'(cnt_ff - 1'b1);
               end
            end
            OP_RADIUS: begin
               if (empty) begin
                  resp.status = ST_EMPTY;
               end else begin
                  load      = 1'b0;
                  state_in  = S_SCAN;
                  rot_in    = '0;
                  rsq_in    = req_data.radius_sq;
                  pend_v_in = 1'b0;
               end
            end
            OP_MEMBER: begin
               if (empty) begin
                  resp.status = ST_EMPTY;
               end else begin
                  resp.found = found;
               end
            end
            default: begin
            end
         endcase
         resp.entry_count = 6'(cnt_in);
      end else if (advance) begin
         if (issue) begin
            ctrl.op = CELL_ROT;
            rot_in  = CW'(rot_ff + 1'b1);
         end
         // a match is held until the next one so the final one can carry last
         if (nout.valid && nout.match) begin
            if (pend_v_ff) begin
               load             = 1'b1;
               resp.point_x     = pend_ff.x;
               resp.point_y     = pend_ff.y;
               resp.point_valid = 1'b1;
               resp.last        = 1'b0;
            end
            pend_in   = nout.pt;
            pend_v_in = 1'b1;
         end else if (scan_done) begin
            load     = 1'b1;
            state_in = S_IDLE;
            if (pend_v_ff) begin
               resp.point_x     = pend_ff.x;
               resp.point_y     = pend_ff.y;
               resp.point_valid = 1'b1;
            end else begin
               resp.status = ST_NOT_FOUND;
            end
         end
         resp.entry_count = 6'(cnt_ff);
      end
      rsp_in       = load ? resp : rsp_ff;
      rsp_valid_in = load | (rsp_valid_ff & rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rot_ff       <= '0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rot_ff       <= rot_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsq_ff  <= rsq_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `ASSERT_CLK(a_occ_matches_count, clock, reset, $countones(occ_vec) == int'(cnt_ff), "occupied cells disagree with count")
   `ASSERT_CLK(a_rot_in_range, clock, reset, (state_ff == S_SCAN) |-> (rot_ff <= cnt_ff), "rotation ran past the list")
   `ASSERT_NEVER(a_no_accept_in_scan, clock, reset, (state_ff == S_SCAN) && !req_stall, "item taken during query")
   `ASSERT_CLK(a_scan_keeps_count, clock, reset, (state_ff == S_SCAN) |=> (cnt_ff == $past(cnt_ff)), "count changed during query")

endmodule

>>> src/plt_cell.sv
module plt_cell import plt_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  point_type     left_pt,
   input  logic          left_occ,
   input  point_type     right_pt,
   input  logic          right_occ,
   input  point_type     head_pt,
   input  logic          seen_in,
   output point_type     pt,
   output logic          occ,
   output logic          seen_out
);

   point_type pt_ff, pt_in;
   logic      occ_ff, occ_in;
   logic      match;

   // exact compare against the key, only for occupied cells
   assign match    = occ_ff && (pt_ff == ctrl.key);
   assign seen_out = seen_in | match;

   // next point and occupancy
   always_comb begin
      pt_in  = pt_ff;
      occ_in = occ_ff;
      case (ctrl.op)
         CELL_PUSH: begin
            pt_in  = left_pt;
            occ_in = left_occ;
         end
         CELL_POP: begin
            pt_in  = right_pt;
            occ_in = right_occ;
         end
         CELL_DEL: begin
            if (seen_out) begin
               pt_in  = right_pt;
               occ_in = right_occ;
            end
         end
         CELL_ROT: begin
            // the last occupied cell wraps around to the head point
            if (occ_ff && !right_occ) begin
               pt_in = head_pt;
            end else begin
               pt_in = right_pt;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      pt_ff <= pt_in;
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   assign pt  = pt_ff;
   assign occ = occ_ff;

endmodule

>>> src/plt_norm.sv
module plt_norm import plt_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  logic         in_valid,
   input  point_type    in_pt,
   input  logic [63:0]  rsq,
   output norm_out_type nout,
   output logic         busy
);

   logic [31:0] xu, yu, ax, ay;
   logic [63:0] xx, yy, sum;

   logic        s1_v_ff, s1_v_in;
   point_type   s1_pt_ff;
   logic [63:0] s1_xx_ff, s1_yy_ff;
   logic        s2_v_ff, s2_v_in;
   logic        s2_match_ff;
   point_type   s2_pt_ff;

   // magnitudes, the most negative value maps to 2^31
   assign xu = in_pt.x;
   assign yu = in_pt.y;
   assign ax = xu[31] ? (~xu + 32'd1) : xu;
   assign ay = yu[31] ? (~yu + 32'd1) : yu;

   // stage one: squares
   assign xx = {32'd0, ax} * {32'd0, ax};
   assign yy = {32'd0, ay} * {32'd0, ay};

   // stage two: sum, at most 2^63 so no carry out
   assign sum = s1_xx_ff + s1_yy_ff;

   assign s1_v_in = advance ? in_valid : s1_v_ff;
   assign s2_v_in = advance ? s1_v_ff : s2_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
      if (advance) begin
         s1_pt_ff    <= in_pt;
         s1_xx_ff    <= xx;
         s1_yy_ff    <= yy;
         s2_pt_ff    <= s1_pt_ff;
         s2_match_ff <= (sum <= rsq);
      end
   end

   assign nout.valid = s2_v_ff;
   assign nout.match = s2_match_ff;
   assign nout.pt    = s2_pt_ff;
   assign busy       = s1_v_ff | s2_v_ff;

endmodule

>>> tb/point_list_table_top_tb.sv
`timescale 1ns / 100ps

module point_list_table_top_tb;
   import plt_pkg::*;

   // opcodes the block must treat as harmless no-ops
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   localparam logic signed [31:0] COORD_MIN  = 32'sh8000_0000;
   localparam logic signed [31:0] COORD_MAX  = 32'sh7fff_ffff;
   localparam logic [63:0]        RADIUS_MAX = 64'h8000_0000_0000_0000;

   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = DEPTH_DEF + 10;
   localparam int MAX_REPORTS  = 10;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // list contents as the block should hold them, oldest at index 0
   point_type stored_points[$];
   // responses still owed by the block, oldest first
   rsp_type   expected_rsps[$];

   bit          no_idle       = 1'b0;
   int unsigned hold_orders   = 0;
   int unsigned hold_served   = 0;
   int          hold_left     = 0;
   int          errors        = 0;
   int          requests_sent = 0;
   int          rsps_checked  = 0;
   int          points_seen   = 0;
   int          full_refusals = 0;
   int          peak_fill     = 0;

   point_list_table_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 4 ns clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // exact squared norm, at most 2^63 so it fits 64 unsigned bits
   function automatic logic [63:0] norm_sq(point_type p);
      logic signed [63:0] sx;
      logic signed [63:0] sy;
      sx = {{32{p.x[31]}}, p.x};
      sy = {{32{p.y[31]}}, p.y};
      return sx * sx + sy * sy;
   endfunction

   // index of the newest stored copy of the item's point, or -1
   function automatic int newest_match(req_type item);
      for (int i = stored_points.size() - 1; i >= 0; i--) begin
         if (stored_points[i].x == item.coord_x && stored_points[i].y == item.coord_y) begin
            return i;
         end
      end
      return -1;
   endfunction

   // apply one item to the list and queue the responses it must produce
   function automatic void predict_results(req_type item);
      rsp_type   r;
      rsp_type   hit_rsp;
      point_type p;
      int        hit;
      int        n_hits;
      int        n_sent;
      r        = '0;
      r.last   = 1'b1;
      r.status = ST_OK;
      case (item.opcode)
         OP_PUSH: begin
            if (stored_points.size() >= DEPTH_DEF) begin
               r.status = ST_FULL;
               full_refusals++;
            end else begin
               p.x = item.coord_x;
               p.y = item.coord_y;
               stored_points.push_back(p);
            end
         end
         OP_POP: begin
            if (stored_points.size() == 0) begin
               r.status = ST_EMPTY;
            end else begin
               void'(stored_points.pop_back());
            end
         end
         OP_DELETE: begin
            hit = newest_match(item);
            if (stored_points.size() == 0) begin
               r.status = ST_EMPTY;
            end else if (hit < 0) begin
               r.status = ST_NOT_FOUND;
            end else begin
               stored_points.delete(hit);
            end
         end
         OP_MEMBER: begin
            if (stored_points.size() == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.found = (newest_match(item) >= 0);
            end
         end
         OP_RADIUS: begin
            if (stored_points.size() == 0) begin
               r.status = ST_EMPTY;
            end else begin
               n_hits = 0;
               foreach (stored_points[i]) begin
                  if (norm_sq(stored_points[i]) <= item.radius_sq) begin
                     n_hits++;
                  end
               end
               if (n_hits == 0) begin
                  r.status = ST_NOT_FOUND;
               end else begin
                  // one response per matching point, newest first
                  n_sent = 0;
                  for (int i = stored_points.size() - 1; i >= 0; i--) begin
                     if (norm_sq(stored_points[i]) <= item.radius_sq) begin
                        n_sent++;
                        hit_rsp             = '0;
                        hit_rsp.point_x     = stored_points[i].x;
                        hit_rsp.point_y     = stored_points[i].y;
                        hit_rsp.point_valid = 1'b1;
                        hit_rsp.entry_count = 6'(stored_points.size());
                        hit_rsp.status      = ST_OK;
                        hit_rsp.last        = (n_sent == n_hits);
                        expected_rsps.push_back(hit_rsp);
                     end
                  end
                  return;
               end
            end
         end
         default: begin
            // count and the spare opcodes change nothing
         end
      endcase
      if (stored_points.size() > peak_fill) begin
         peak_fill = stored_points.size();
      end
      r.entry_count = 6'(stored_points.size());
      expected_rsps.push_back(r);
   endfunction

   function automatic req_type make_req(logic [2:0] op, logic signed [31:0] x,
                                        logic signed [31:0] y, logic [63:0] rsq);
      req_type item;
      item.opcode    = op;
      item.coord_x   = x;
      item.coord_y   = y;
      item.radius_sq = rsq;
      return item;
   endfunction

   // small values most often so points repeat, some extremes, some full range
   function automatic logic signed [31:0] random_coord();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         return 32'($urandom_range(0, 8)) - 32'd4;
      end
      if (pick < 60) begin
         case ($urandom_range(0, 3))
            0:       return COORD_MIN;
            1:       return COORD_MAX;
            2:       return '0;
            default: return '1;
         endcase
      end
      return $urandom;
   endfunction

   function automatic req_type random_request();
      req_type   item;
      point_type p;
      int        pick;
      item.coord_x = random_coord();
      item.coord_y = random_coord();
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         item.radius_sq = '0;
      end else if (pick == 1) begin
         item.radius_sq = RADIUS_MAX;
      end else if (pick < 5) begin
         item.radius_sq = 64'($urandom_range(0, 40));
      end else begin
         item.radius_sq = {1'b0, 31'($urandom), 32'($urandom)};
      end
      pick = $urandom_range(0, 99);
      if (pick < 34) begin
         item.opcode = OP_PUSH;
      end else if (pick < 44) begin
         item.opcode = OP_POP;
      end else if (pick < 58) begin
         item.opcode = OP_DELETE;
      end else if (pick < 73) begin
         item.opcode = OP_RADIUS;
      end else if (pick < 88) begin
         item.opcode = OP_MEMBER;
      end else if (pick < 96) begin
         item.opcode = OP_COUNT;
      end else begin
         item.opcode = pick[0] ? OP_SPARE_7 : OP_SPARE_6;
      end
      // aim deletes and membership tests at stored points, duplicate some pushes
      if (stored_points.size() != 0) begin
         p = stored_points[$urandom_range(0, stored_points.size() - 1)];
         if (((item.opcode == OP_DELETE || item.opcode == OP_MEMBER) &&
              $urandom_range(0, 3) != 0) ||
             (item.opcode == OP_PUSH && $urandom_range(0, 4) == 0)) begin
            item.coord_x = p.x;
            item.coord_y = p.y;
         end
         // bound placed exactly on a stored norm
         if (item.opcode == OP_RADIUS && $urandom_range(0, 2) == 0) begin
            item.radius_sq = norm_sq(p);
         end
      end
      return item;
   endfunction

   // offer one item, wait for the block to take it, then predict
   task automatic offer_request(input req_type item);
      if (!no_idle && $urandom_range(0, 99) < 19) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      predict_results(item);
      requests_sent++;
   endtask

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
         errors++;
         if (errors <= MAX_REPORTS) begin
            $display("response %0d %s mismatch: expected %h, got %h",
                     rsps_checked, name, want, got);
         end
      end
   endtask

   // result side: random stall, or a long hold when one is ordered
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_orders) begin
         rsp_stall   <= 1'b1;
         hold_left   <= HOLD_CYCLES - 1;
         hold_served <= hold_orders;
      end else begin
         rsp_stall <= !no_idle && ($urandom_range(0, 99) < 19);
      end
   end

   // compare each accepted response with the oldest one owed
   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("unexpected response: %p", rsp_data);
            end
         end else begin
            want = expected_rsps.pop_front();
            check_field("point_x", want.point_x, rsp_data.point_x);
            check_field("point_y", want.point_y, rsp_data.point_y);
            check_field("point_valid", want.point_valid, rsp_data.point_valid);
            check_field("found", want.found, rsp_data.found);
            check_field("entry_count", want.entry_count, rsp_data.entry_count);
            check_field("status", want.status, rsp_data.status);
            check_field("last", want.last, rsp_data.last);
            rsps_checked++;
            if (want.point_valid) begin
               points_seen++;
            end
         end
      end
   end

   // every operation but push on an empty list, spare opcodes included
   task automatic test_empty_list();
      offer_request(make_req(OP_COUNT, 0, 0, 0));
      offer_request(make_req(OP_POP, 0, 0, 0));
      offer_request(make_req(OP_DELETE, 1, 2, 0));
      offer_request(make_req(OP_MEMBER, 1, 2, 0));
      offer_request(make_req(OP_RADIUS, 0, 0, RADIUS_MAX));
      offer_request(make_req(OP_SPARE_6, COORD_MIN, COORD_MAX, RADIUS_MAX));
      offer_request(make_req(OP_SPARE_7, '1, '1, 64'h1234));
   endtask

   // extremes, duplicates, newest-match delete and radius bounds
   task automatic test_directed_ops();
      offer_request(make_req(OP_PUSH, COORD_MIN, COORD_MIN, 0));
      offer_request(make_req(OP_PUSH, COORD_MAX, COORD_MAX, 0));
      offer_request(make_req(OP_PUSH, 0, 0, 0));
      offer_request(make_req(OP_PUSH, 3, 4, 0));
      offer_request(make_req(OP_PUSH, -3, -4, 0));
      offer_request(make_req(OP_PUSH, 3, 4, 0));
      offer_request(make_req(OP_PUSH, COORD_MIN, COORD_MAX, 0));
      offer_request(make_req(OP_COUNT, 0, 0, 0));
      offer_request(make_req(OP_MEMBER, 3, 4, 0));
      offer_request(make_req(OP_MEMBER, 4, 3, 0));
      offer_request(make_req(OP_RADIUS, 0, 0, 64'd25));
      offer_request(make_req(OP_RADIUS, 0, 0, RADIUS_MAX));
      // one below the largest norm drops only the most negative corner
      offer_request(make_req(OP_RADIUS, 0, 0, RADIUS_MAX - 1));
      offer_request(make_req(OP_DELETE, 3, 4, 0));
      offer_request(make_req(OP_MEMBER, 3, 4, 0));
      offer_request(make_req(OP_DELETE, 7, 7, 0));
      offer_request(make_req(OP_DELETE, 0, 0, 0));
      // nothing left at the origin, so no match
      offer_request(make_req(OP_RADIUS, 0, 0, 64'd0));
      offer_request(make_req(OP_POP, 0, 0, 0));
      offer_request(make_req(OP_SPARE_6, 5, 5, 0));
      offer_request(make_req(OP_COUNT, 0, 0, 0));
   endtask

   // fill to capacity, refuse pushes, full-length radius query, then thin out
   task automatic test_full_list();
      point_type p;
      while (stored_points.size() < DEPTH_DEF) begin
         offer_request(make_req(OP_PUSH, random_coord(), random_coord(), 0));
      end
      offer_request(make_req(OP_PUSH, 1, 1, 0));
      offer_request(make_req(OP_PUSH, COORD_MAX, COORD_MIN, 0));
      offer_request(make_req(OP_COUNT, 0, 0, 0));
      offer_request(make_req(OP_RADIUS, 0, 0, RADIUS_MAX));
      repeat (10) begin
         p = stored_points[$urandom_range(0, stored_points.size() - 1)];
         offer_request(make_req(OP_DELETE, p.x, p.y, 0));
      end
      repeat (8) offer_request(make_req(OP_POP, 0, 0, 0));
   endtask

   // result side held off long enough for the block to back up its input
   task automatic test_backpressure();
      hold_orders <= hold_orders + 1;
      repeat (16) offer_request(random_request());
   endtask

   // back-to-back items with no idling on either side
   task automatic test_burst();
      no_idle = 1'b1;
      repeat (60) offer_request(random_request());
      no_idle = 1'b0;
   endtask

   task automatic test_random();
      repeat (180) offer_request(random_request());
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_list();
      test_directed_ops();
      test_full_list();
      test_backpressure();
      test_burst();
      test_random();

      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      errors += expected_rsps.size();

      $display("%0d items sent, %0d responses checked, %0d radius points returned",
               requests_sent, rsps_checked, points_seen);
      $display("list peaked at %0d of %0d entries, %0d pushes refused as full",
               peak_fill, DEPTH_DEF, full_refusals);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // run limit
   initial begin
      #2_000_000;
      $display("timeout with %0d responses outstanding", expected_rsps.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule
